// ===== hdl/ue2u_pkg.sv =====
// Package for the <U+hhhh> unescaper: byte and queue-entry types, escape
// characters, and the hex-digit helpers used by the front stage.
// No dependencies.
package ue2u_pkg;

	localparam int WinDepth = 8;
	localparam int WinIdxW  = $clog2(WinDepth);

	typedef logic [7:0] byte_t;
	typedef logic [WinIdxW-1:0] win_idx_t;

	localparam byte_t ChLt   = 8'h3C;
	localparam byte_t ChU    = 8'h55;
	localparam byte_t ChPlus = 8'h2B;
	localparam byte_t ChGt   = 8'h3E;
	localparam byte_t Ch0    = 8'h30;
	localparam byte_t Ch9    = 8'h39;
	localparam byte_t ChA    = 8'h41;
	localparam byte_t ChF    = 8'h46;

	// One queue entry: up to eight output words, their count less one, end flag.
	typedef struct packed {
		byte_t [WinDepth-1:0] data;
		win_idx_t              cnt_m1;
		logic                  last;
	} entry_t;

	function automatic logic is_hex(input byte_t c);
		return ((c >= Ch0) && (c <= Ch9)) || ((c >= ChA) && (c <= ChF));
	endfunction

	function automatic logic [3:0] hex_val(input byte_t c);
		byte_t d;
		if (c <= Ch9) begin
			d = c - Ch0;
		end else begin
			d = c - ChA + 8'd10;
		end
		return d[3:0];
	endfunction

endpackage

// ===== hdl/ue2u_if.sv =====
// Stream interfaces for the unescaper: input bytes and output bytes, each
// with valid/ready. Uses ue2u_pkg.
interface ue2u_in_if import ue2u_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface ue2u_out_if import ue2u_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/ue2u_front.sv =====
// Front stage: look-ahead window, escape match and UTF-8 encode; emits one
// queue entry per decision. Uses ue2u_pkg and ue2u_in_if.
module ue2u_front import ue2u_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ue2u_in_if.sink       rx,
	input  logic          q_full,
	output logic          push,
	output entry_t        push_entry
);

	byte_t [WinDepth-2:0] win_q;
	win_idx_t             fill_q;
	byte_t [WinDepth-1:0] nw;
	logic                 accept;
	logic                 full_win;
	logic                 match;
	logic [15:0]          cp;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign full_win = (fill_q == win_idx_t'(WinDepth - 1));
	assign push     = accept && (rx.in_last || full_win);

	always_comb begin
		for (int i = 0; i < WinDepth - 1; i++) begin
			if (win_idx_t'(i) < fill_q) begin
				nw[i] = win_q[i];
			end else if (win_idx_t'(i) == fill_q) begin
				nw[i] = rx.in_byte;
			end else begin
				nw[i] = '0;
			end
		end
		nw[WinDepth-1] = full_win ? rx.in_byte : '0;
	end

	assign match = full_win && (nw[0] == ChLt) && (nw[1] == ChU) && (nw[2] == ChPlus)
		&& (nw[7] == ChGt) && is_hex(nw[3]) && is_hex(nw[4]) && is_hex(nw[5])
		&& is_hex(nw[6]);
	assign cp = {hex_val(nw[3]), hex_val(nw[4]), hex_val(nw[5]), hex_val(nw[6])};

	always_comb begin
		push_entry      = '0;
		push_entry.last = rx.in_last;
		if (match) begin
			if (cp < 16'h0080) begin
				push_entry.data[0] = cp[7:0];
				push_entry.cnt_m1  = win_idx_t'(0);
			end else if (cp < 16'h0800) begin
				push_entry.data[0] = {3'b110, cp[10:6]};
				push_entry.data[1] = {2'b10, cp[5:0]};
				push_entry.cnt_m1  = win_idx_t'(1);
			end else begin
				push_entry.data[0] = {4'b1110, cp[15:12]};
				push_entry.data[1] = {2'b10, cp[11:6]};
				push_entry.data[2] = {2'b10, cp[5:0]};
				push_entry.cnt_m1  = win_idx_t'(2);
			end
		end else if (rx.in_last) begin
			push_entry.data   = nw;
			push_entry.cnt_m1 = fill_q;
		end else begin
			push_entry.data[0] = nw[0];
			push_entry.cnt_m1  = win_idx_t'(0);
		end
	end

	// shift the window by one on a head copy, otherwise append in place
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WinDepth - 1; i++) begin
				win_q[i] <= (full_win && !match) ? nw[i+1] : nw[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (rx.in_last || match) begin
				fill_q <= '0;
			end else if (!full_win) begin
				fill_q <= fill_q + win_idx_t'(1);
			end
		end
	end

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx.in_last |=> fill_q == '0)
		else $error("window not emptied after end of string");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !rx.in_last && !full_win |=> fill_q == $past(fill_q) + win_idx_t'(1))
		else $error("window fill did not advance");

endmodule

// ===== hdl/ue2u_queue.sv =====
// Short queue of entries between front and back stages.
// Uses ue2u_pkg.
module ue2u_queue import ue2u_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	entry_t [Depth-1:0] mem_q;
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    cnt_q;

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ===== hdl/ue2u_back.sv =====
// Back stage: walks the queue head entry word by word into the output
// register. Uses ue2u_pkg and ue2u_out_if.
module ue2u_back import ue2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  entry_t    head,
	output logic      pop,
	ue2u_out_if.source tx
);

	win_idx_t idx_q;
	logic     out_valid_q;
	byte_t    out_byte_q;
	logic     out_last_q;
	logic     load;
	logic     end_of_entry;

	assign load         = head_valid && (!out_valid_q || tx.ready);
	assign end_of_entry = (idx_q == head.cnt_m1);
	assign pop          = load && end_of_entry;

	assign tx.valid    = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.out_last = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.data[idx_q];
			out_last_q <= head.last && end_of_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= end_of_entry ? '0 : idx_q + win_idx_t'(1);
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.cnt_m1)
		else $error("word index past end of entry");

endmodule

// ===== hdl/unicode_escape_to_utf8.sv =====
// Top level of the <U+hhhh> to UTF-8 unescaper: front stage, entry queue,
// back stage. Uses ue2u_pkg, ue2u_if, ue2u_front, ue2u_queue, ue2u_back.
//
// One input byte is taken every cycle while the entry queue is not full, and
// one output byte leaves every cycle while words wait and tx.ready is high.
// The front stage keeps a seven-byte window; the byte that fills it to eight
// is matched against <U+hhhh> (uppercase hex only) in the same cycle, and a
// match becomes one to three UTF-8 words, otherwise the head byte is passed
// on. The final byte of a string releases the whole window, up to eight
// words, which the back stage sends one per cycle while tx.ready is high.
// The first output word of a decision passes through the entry queue and then
// the output register. The input stalls only when the QueueDepth-entry queue
// is full, which happens when the output side is held or while a string end
// drains. No memory clearing after reset.
module unicode_escape_to_utf8 import ue2u_pkg::*; #(
	parameter int QueueDepth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ue2u_in_if.sink    rx,
	ue2u_out_if.source tx
);

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   head_valid;
	entry_t head;

	ue2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ue2u_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ue2u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

// ===== dv/tb_unicode_escape_to_utf8.sv =====
`timescale 1ns / 1ps
// Testbench for unicode_escape_to_utf8: directed strings, then random strings of
// escapes, broken escapes and plain bytes, checked word by word against a predictor.
// Depends on ue2u_pkg, ue2u_in_if, ue2u_out_if and the unicode_escape_to_utf8 RTL.
module tb_unicode_escape_to_utf8;
	import ue2u_pkg::*;

	localparam int NumRandItems = 80;
	localparam int HoldCycles   = 100;
	localparam int DrainCycles  = 20;

	typedef struct packed {
		byte_t data;
		logic  last;
	} word_t;

	typedef struct {
		byte_t b;
		logic  last;
		int    n;
		byte_t e[3];
	} row_t;

	logic clk;
	logic arst_n;

	ue2u_in_if  in_ch ();
	ue2u_out_if out_ch ();

	unicode_escape_to_utf8 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (in_ch),
		.tx     (out_ch)
	);

	// Predictor state: look-ahead window, oldest byte at index 0.
	byte_t       win [WinDepth];
	int unsigned fill;

	word_t utf8_q [$];
	int    errors;
	bit    hold_req;
	bit    no_gaps;
	bit    in_calm;
	bit    out_calm;

	// n < 0: take the expected words from the predictor.
	row_t dir_rows [26] = '{
		'{ChLt, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChU, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChPlus, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{Ch0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{Ch0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{Ch0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{Ch0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChGt, 1'b1, 1, '{8'h00, 8'h00, 8'h00}},
		'{ChLt, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChU, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChPlus, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChF, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChF, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChF, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChF, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChGt, 1'b0, 3, '{8'hEF, 8'hBF, 8'hBF}},
		'{8'h00, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{8'hFF, 1'b1, 2, '{8'h00, 8'hFF, 8'h00}},
		'{ChLt, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChU, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChPlus, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{"1", 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{"2", 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{"a", 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{"4", 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
		'{ChGt, 1'b1, -1, '{8'h00, 8'h00, 8'h00}}
	};

	function automatic bit escape_at_head(output logic [15:0] cp);
		byte_t c;
		cp = '0;
		if (fill != WinDepth) return 1'b0;
		if (win[0] != ChLt || win[1] != ChU || win[2] != ChPlus || win[7] != ChGt)
			return 1'b0;
		for (int k = 3; k < 7; k++) begin
			c = win[k];
			if (c >= Ch0 && c <= Ch9) begin
				cp = {cp[11:0], 4'(c - Ch0)};
			end else if (c >= ChA && c <= ChF) begin
				cp = {cp[11:0], 4'(c - ChA + 8'd10)};
			end else begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Encode the escape at the head, or pass the head byte on.
	function automatic void settle_head(ref word_t res[$]);
		logic [15:0] cp;
		if (escape_at_head(cp)) begin
			if (cp < 16'h0080) begin
				res.push_back('{cp[7:0], 1'b0});
			end else if (cp < 16'h0800) begin
				res.push_back('{{3'b110, cp[10:6]}, 1'b0});
				res.push_back('{{2'b10, cp[5:0]}, 1'b0});
			end else begin
				res.push_back('{{4'b1110, cp[15:12]}, 1'b0});
				res.push_back('{{2'b10, cp[11:6]}, 1'b0});
				res.push_back('{{2'b10, cp[5:0]}, 1'b0});
			end
			fill = 0;
		end else if (fill > 0) begin
			res.push_back('{win[0], 1'b0});
			for (int k = 0; k < WinDepth - 1; k++)
				win[k] = win[k + 1];
			fill--;
		end
	endfunction

	function automatic void unescape_byte(input byte_t b, input logic last,
			ref word_t res[$]);
		win[fill] = b;
		fill++;
		if (last) begin
			while (fill > 0)
				settle_head(res);
			res[res.size() - 1].last = 1'b1;
		end else if (fill == WinDepth) begin
			settle_head(res);
		end
	endfunction

	function automatic int draw_wait(ref bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	function automatic byte_t hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? byte_t'(Ch0 + nib) : byte_t'(ChA + nib - 4'd10);
	endfunction

	function automatic logic [15:0] pick_code_point();
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hFFFF));
			3: return 16'($urandom_range(16'hD800, 16'hDFFF));
			4: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h007F;
					2: return 16'h0080;
					3: return 16'h07FF;
					4: return 16'h0800;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_byte(input byte_t b, input logic last, ref word_t res[$]);
		int gap;
		gap = no_gaps ? 0 : draw_wait(in_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do @(posedge clk); while (!in_ch.ready);
		res.delete();
		unescape_byte(b, last, res);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: draw a stall per word, hold off long once on request.
	initial begin
		int    stall;
		word_t want;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait(out_calm);
			if (hold_req) begin
				stall    = HoldCycles;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (utf8_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual %02h last %0b",
					$time, out_ch.out_byte, out_ch.out_last);
			end else begin
				want = utf8_q.pop_front();
				if (out_ch.out_byte !== want.data) begin
					errors++;
					$display("%0t: out_byte mismatch: expected %02h, actual %02h",
						$time, want.data, out_ch.out_byte);
				end
				if (out_ch.out_last !== want.last) begin
					errors++;
					$display("%0t: out_last mismatch: expected %0b, actual %0b",
						$time, want.last, out_ch.out_last);
				end
			end
		end
	end

	initial begin
		word_t       res [$];
		byte_t       str [$];
		int          sent;
		int          strings;
		int          base;
		int          idx;
		logic [15:0] cp;
		byte_t       c;

		errors        = 0;
		hold_req      = 1'b0;
		no_gaps       = 1'b0;
		in_calm       = 1'b0;
		out_calm      = 1'b0;
		fill          = 0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = '0;
		in_ch.in_last = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].b, dir_rows[i].last, res);
			if (dir_rows[i].n < 0) begin
				foreach (res[k]) utf8_q.push_back(res[k]);
			end else begin
				for (int k = 0; k < dir_rows[i].n; k++)
					utf8_q.push_back('{dir_rows[i].e[k],
						dir_rows[i].last && (k == dir_rows[i].n - 1)});
			end
		end

		sent    = 0;
		strings = 0;
		while (sent < NumRandItems) begin
			str.delete();
			if (strings == 1) begin
				// back up the output: long receiver hold while bytes keep coming
				hold_req = 1'b1;
				no_gaps  = 1'b1;
				repeat (40) str.push_back(byte_t'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5, 6, 7: begin
							cp   = pick_code_point();
							base = str.size();
							str.push_back(ChLt);
							str.push_back(ChU);
							str.push_back(ChPlus);
							str.push_back(hex_char(cp[15:12]));
							str.push_back(hex_char(cp[11:8]));
							str.push_back(hex_char(cp[7:4]));
							str.push_back(hex_char(cp[3:0]));
							str.push_back(ChGt);
							// break one in four: lowercase a digit or clobber a byte
							if ($urandom_range(0, 3) == 0) begin
								idx = base + $urandom_range(0, 7);
								c   = str[idx];
								if (c >= ChA && c <= ChF)
									str[idx] = c | 8'h20;
								else
									str[idx] = byte_t'($urandom_range(0, 255));
							end
						end
						default: begin
							repeat ($urandom_range(1, 6))
								str.push_back(($urandom_range(0, 3) == 0) ? ChLt
									: byte_t'($urandom_range(0, 255)));
						end
					endcase
				end
			end
			foreach (str[i]) begin
				send_byte(str[i], i == str.size() - 1, res);
				foreach (res[k]) utf8_q.push_back(res[k]);
			end
			sent += str.size();
			no_gaps = 1'b0;
			strings++;
			if (strings % 3 == 0) begin
				// hold the input until the output has caught up
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (utf8_q.size() != 0) @(posedge clk);
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (utf8_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
